// File: sv/tdcc_pkg.sv
// ----------------------------------------------------------------------------
// tdcc_pkg: shared types and constants for the tick driven calendar clock
// Item and result structs, calendar constants, BCD and month table helpers.
// ----------------------------------------------------------------------------
package tdcc_pkg;

  localparam int CMD_QUEUE_DEPTH = 2;

  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd100;
  localparam logic [31:0] SECS_PER_MINUTE = 32'd60;
  localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [31:0] SECS_PER_YEAR   = 32'd31536000;
  localparam logic [31:0] CENTURY_SECS    = 32'd3153600000;
  localparam logic [11:0] YEAR_BASE       = 12'd2000;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] bcd_second;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_day;
    logic [7:0] bcd_month;
    logic [7:0] bcd_year;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } out_item_t;

  // Classified command between front and back; fields already binary.
  typedef struct packed {
    logic       is_load;
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [8:0] day_of_year;
    logic [7:0] year;
  } cmd_t;

  // Nibbles above 9 are weighted as is (high * 10 + low).
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
  endfunction

  // First day of each month, zero based, 365 day year.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/tick_driven_calendar_clock.sv
// ----------------------------------------------------------------------------
// tick_driven_calendar_clock: seconds counter with calendar readout
// Counts timer ticks into seconds since 2000-01-01 (365 day years, wraps
// after 2099); loads from BCD fields; returns binary date and time per item.
// ----------------------------------------------------------------------------
// Each transaction (tick or BCD load) returns one result: the date and time
// after the update. The time unit takes the command, splits the count into
// year, day, hour and minute, each quotient by a reciprocal multiply
// estimate, a multiply-subtract and one correction, and registers the
// result; a load first sums the weighted fields and applies the century wrap.
// Items are handled one at a time; a command queue of QUEUE_DEPTH entries in
// front and a result register behind let either side stall on its own.
// ticks_per_second of zero counts 65536.
module tick_driven_calendar_clock #(
  parameter int QUEUE_DEPTH = tdcc_pkg::CMD_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tdcc_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output tdcc_pkg::out_item_t result,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import tdcc_pkg::*;

  logic [15:0] ticks_per_second;
  cmd_t        front_cmd;
  cmd_t        queue_cmd;
  logic        queue_empty;
  logic        queue_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_PER_SECOND_RESET;
    end else if (cfg_we) begin
      ticks_per_second <= cfg_data;
    end
  end

  tdcc_front u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  tdcc_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (queue_pop),
    .rdata (queue_cmd),
    .empty (queue_empty)
  );

  tdcc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .ticks_per_second (ticks_per_second),
    .cmd_empty        (queue_empty),
    .cmd              (queue_cmd),
    .cmd_pop          (queue_pop),
    .res_pop          (pop),
    .res_empty        (empty),
    .res              (result)
  );

endmodule

// File: sv/tdcc_front.sv
// ----------------------------------------------------------------------------
// tdcc_front: item decoder
// Turns an input item into a command: BCD fields to binary, month clamped
// to 1..12, day zero taken as one, both folded into a zero based day of year.
// ----------------------------------------------------------------------------
module tdcc_front (
  input  tdcc_pkg::in_item_t item,
  output tdcc_pkg::cmd_t     cmd
);
  import tdcc_pkg::*;

  logic [7:0] dom;
  logic [7:0] mon;
  logic [3:0] mon_idx;
  logic [7:0] dom_idx;

  always_comb begin
    dom = bcd_value(item.bcd_day);
    mon = bcd_value(item.bcd_month);
    dom_idx = (dom == 8'd0) ? 8'd0 : dom - 8'd1;
    if (mon <= 8'd1) begin
      mon_idx = 4'd0;
    end else if (mon >= 8'd12) begin
      mon_idx = 4'd11;
    end else begin
      mon_idx = 4'(mon - 8'd1);
    end
    cmd.is_load     = (item.func == FUNC_LOAD);
    cmd.second      = bcd_value(item.bcd_second);
    cmd.minute      = bcd_value(item.bcd_minute);
    cmd.hour        = bcd_value(item.bcd_hour);
    cmd.day_of_year = {1'b0, dom_idx} + month_start(mon_idx);
    cmd.year        = bcd_value(item.bcd_year);
  end

endmodule

// File: sv/tdcc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tdcc_cmd_fifo: command queue
// Small first-in first-out queue between the decoder and the time unit.
// ----------------------------------------------------------------------------
module tdcc_cmd_fifo #(
  parameter int DEPTH = tdcc_pkg::CMD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tdcc_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output tdcc_pkg::cmd_t rdata,
  output logic           empty
);
  import tdcc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: sv/tdcc_back.sv
// ----------------------------------------------------------------------------
// tdcc_back: time unit
// Holds the prescaler and second count, applies ticks and loads, and splits
// the count into calendar fields by reciprocal multiplication with a
// one-step correction.
// ----------------------------------------------------------------------------
module tdcc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         ticks_per_second,
  input  logic                cmd_empty,
  input  tdcc_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_pop,
  output logic                res_empty,
  output tdcc_pkg::out_item_t res
);
  import tdcc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_WRAP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] PH_YEAR = 2'd0;
  localparam logic [1:0] PH_DAY  = 2'd1;
  localparam logic [1:0] PH_HOUR = 2'd2;
  localparam logic [1:0] PH_MIN  = 2'd3;

  localparam logic [1:0] STEP_EST = 2'd0;
  localparam logic [1:0] STEP_SUB = 2'd1;
  localparam logic [1:0] STEP_FIX = 2'd2;

  // floor(2^k / divisor), k covering the dividend range of each stage, so the
  // estimate is the quotient or one below it
  localparam logic [8:0] YEAR_RECIP = 9'd136;  // k = 32
  localparam logic [8:0] DAY_RECIP  = 9'd388;  // k = 25
  localparam logic [8:0] HOUR_RECIP = 9'd36;   // k = 17
  localparam logic [8:0] MIN_RECIP  = 9'd68;   // k = 12

  localparam logic [2:0] TERM_SEC  = 3'd0;
  localparam logic [2:0] TERM_MIN  = 3'd1;
  localparam logic [2:0] TERM_HOUR = 3'd2;
  localparam logic [2:0] TERM_DAY  = 3'd3;
  localparam logic [2:0] TERM_YEAR = 3'd4;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic [1:0]  step;
  logic [2:0]  term;
  cmd_t        cmd_q;
  logic [32:0] acc;
  logic [15:0] prescaler;
  logic [31:0] elapsed;
  logic [31:0] rem;
  logic [8:0]  q;
  logic [6:0]  years;
  logic [8:0]  yday;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic        res_valid;
  out_item_t   res_q;

  logic [24:0] div_c;
  logic [8:0]  recip;
  logic [40:0] est_prod;
  logic [8:0]  q_est;
  logic [33:0] qd;
  logic        fix;
  logic [8:0]  q_fix;
  logic [16:0] limit;
  logic [16:0] presc_inc;
  logic        second_done;
  logic [31:0] elapsed_tick;
  logic [8:0]  operand;
  logic [24:0] weight;
  logic [33:0] product;
  logic [33:0] acc_sum;
  logic [32:0] wrapped;
  logic [3:0]  mi;
  out_item_t   res_calc;
  logic        res_free;

  assign cmd_pop   = (state == ST_IDLE) && !cmd_empty;
  assign res_empty = !res_valid;
  assign res       = res_q;
  assign res_free  = !res_valid || res_pop;

  // divisor and reciprocal of the current stage
  always_comb begin
    case (phase)
      PH_YEAR: begin
        div_c = SECS_PER_YEAR[24:0];
        recip = YEAR_RECIP;
      end
      PH_DAY: begin
        div_c = SECS_PER_DAY[24:0];
        recip = DAY_RECIP;
      end
      PH_HOUR: begin
        div_c = SECS_PER_HOUR[24:0];
        recip = HOUR_RECIP;
      end
      default: begin
        div_c = SECS_PER_MINUTE[24:0];
        recip = MIN_RECIP;
      end
    endcase
  end

  assign est_prod = {9'b0, rem} * {32'b0, recip};

  always_comb begin
    case (phase)
      PH_YEAR: q_est = est_prod[40:32];
      PH_DAY:  q_est = est_prod[33:25];
      PH_HOUR: q_est = est_prod[25:17];
      default: q_est = est_prod[20:12];
    endcase
  end

  assign qd    = {25'b0, q} * {9'b0, div_c};
  assign fix   = (rem >= {7'b0, div_c});
  assign q_fix = fix ? q + 9'd1 : q;

  // a register value of zero means 65536 ticks
  assign limit        = (ticks_per_second == 16'd0) ? 17'h10000 : {1'b0, ticks_per_second};
  assign presc_inc    = {1'b0, prescaler} + 17'd1;
  assign second_done  = (presc_inc >= limit);
  assign elapsed_tick = !second_done ? elapsed :
                        (elapsed == CENTURY_SECS - 32'd1) ? 32'd0 : elapsed + 32'd1;

  // load sum: one weighted term per cycle
  always_comb begin
    case (term)
      TERM_SEC: begin
        operand = {1'b0, cmd_q.second};
        weight  = 25'd1;
      end
      TERM_MIN: begin
        operand = {1'b0, cmd_q.minute};
        weight  = SECS_PER_MINUTE[24:0];
      end
      TERM_HOUR: begin
        operand = {1'b0, cmd_q.hour};
        weight  = SECS_PER_HOUR[24:0];
      end
      TERM_DAY: begin
        operand = cmd_q.day_of_year;
        weight  = SECS_PER_DAY[24:0];
      end
      TERM_YEAR: begin
        operand = {1'b0, cmd_q.year};
        weight  = SECS_PER_YEAR[24:0];
      end
      default: begin
        operand = 9'd0;
        weight  = 25'd0;
      end
    endcase
  end

  assign product = {25'b0, operand} * {9'b0, weight};
  assign acc_sum = {1'b0, acc} + product;
  // load total stays below two centuries
  assign wrapped = (acc >= {1'b0, CENTURY_SECS}) ? acc - {1'b0, CENTURY_SECS} : acc;

  always_comb begin
    mi = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (yday >= month_start(4'(i))) mi = 4'(i);
    end
    res_calc.second = rem[5:0];
    res_calc.minute = minutes;
    res_calc.hour   = hours;
    res_calc.day    = 5'(yday - month_start(mi) + 9'd1);
    res_calc.month  = mi + 4'd1;
    res_calc.year   = YEAR_BASE + {5'b0, years};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prescaler <= '0;
      elapsed   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop && res_valid && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cmd_q <= cmd;
            if (cmd.is_load) begin
              acc   <= '0;
              term  <= TERM_SEC;
              state <= ST_LOAD;
            end else begin
              prescaler <= second_done ? 16'd0 : presc_inc[15:0];
              elapsed   <= elapsed_tick;
              rem       <= elapsed_tick;
              step      <= STEP_EST;
              phase     <= PH_YEAR;
              state     <= ST_DIV;
            end
          end
        end
        ST_LOAD: begin
          acc <= acc_sum[32:0];
          if (term == TERM_YEAR) begin
            state <= ST_WRAP;
          end else begin
            term <= term + 3'd1;
          end
        end
        ST_WRAP: begin
          prescaler <= '0;
          elapsed   <= wrapped[31:0];
          rem       <= wrapped[31:0];
          step      <= STEP_EST;
          phase     <= PH_YEAR;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          case (step)
            STEP_EST: begin
              q    <= q_est;
              step <= STEP_SUB;
            end
            STEP_SUB: begin
              rem  <= rem - qd[31:0];
              step <= STEP_FIX;
            end
            default: begin
              // estimate was one short: take one more divisor off
              if (fix) begin
                rem <= rem - {7'b0, div_c};
              end
              step <= STEP_EST;
              case (phase)
                PH_YEAR: begin
                  years <= q_fix[6:0];
                  phase <= PH_DAY;
                end
                PH_DAY: begin
                  yday  <= q_fix;
                  phase <= PH_HOUR;
                end
                PH_HOUR: begin
                  hours <= q_fix[4:0];
                  phase <= PH_MIN;
                end
                default: begin
                  minutes <= q_fix[5:0];
                  state   <= ST_DONE;
                end
              endcase
            end
          endcase
        end
        ST_DONE: begin
          if (res_free) begin
            res_q     <= res_calc;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for tick_driven_calendar_clock
// Drives tick and BCD load transactions through the push/full side and pops
// calendar readouts, comparing each with a behavioral bench calendar or a typed
// readout. A short directed table covers reset, extremes, clamping and the
// century wrap; random phases follow at several ticks-per-second settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tdcc_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE  = 103;
  localparam int NUM_PHASES       = 9;

  localparam int unsigned MONTH_FIRST_DAY [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  localparam in_item_t TICK_ITEM = '{func: FUNC_TICK, default: '0};

  typedef struct {
    bit          is_cfg;
    logic [15:0] tps;
    in_item_t    stim;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  in_item_t    item = '0;
  logic        pop = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        full;
  logic        empty;
  out_item_t   result;

  // bench-side copy of the clock state
  logic [15:0] model_tps = TICKS_PER_SECOND_RESET;
  logic [15:0] model_prescale = '0;
  logic [31:0] model_elapsed = '0;

  out_item_t   expected_readout_q [$];
  dir_row_t    directed_rows [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          hold_taken = 1'b0;
  logic        hold_req = 1'b0;
  logic        idle_on = 1'b1;

  tick_driven_calendar_clock dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tick_driven_calendar_clock regression: fail");
      $finish;
    end
  end

  function automatic int unsigned bcd_to_bin(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] bin_to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Applies one transaction to the bench calendar, returns the readout after it.
  function automatic out_item_t advance_calendar(input in_item_t it);
    longint unsigned total;
    int unsigned     sec, mins, hrs, dom, mon_in, yr_in;
    int unsigned     limit, nxt, s, yr, days, rem;
    int              mon;
    out_item_t       r;
    if (it.func == FUNC_LOAD) begin
      sec    = bcd_to_bin(it.bcd_second);
      mins   = bcd_to_bin(it.bcd_minute);
      hrs    = bcd_to_bin(it.bcd_hour);
      dom    = bcd_to_bin(it.bcd_day);
      mon_in = bcd_to_bin(it.bcd_month);
      yr_in  = bcd_to_bin(it.bcd_year);
      if (dom < 1) dom = 1;
      if (mon_in < 1) mon_in = 1;
      if (mon_in > 12) mon_in = 12;
      total = 64'(sec) + 64'(mins) * 60 + 64'(hrs) * 3600
            + 64'(dom - 1) * SECS_PER_DAY
            + 64'(MONTH_FIRST_DAY[mon_in - 1]) * SECS_PER_DAY
            + 64'(yr_in) * SECS_PER_YEAR;
      model_elapsed  = 32'(total % CENTURY_SECS);
      model_prescale = '0;
    end else begin
      limit = (model_tps == 0) ? 65536 : model_tps;
      nxt   = model_prescale + 1;
      // also covers a prescaler left above a newly lowered limit
      if (nxt >= limit) begin
        model_prescale = '0;
        model_elapsed  = model_elapsed + 1;
        if (model_elapsed >= CENTURY_SECS) model_elapsed = '0;
      end else begin
        model_prescale = nxt[15:0];
      end
    end
    s    = model_elapsed % CENTURY_SECS;
    yr   = s / SECS_PER_YEAR;
    s    = s % SECS_PER_YEAR;
    days = s / SECS_PER_DAY;
    rem  = s % SECS_PER_DAY;
    mon  = 11;
    while (mon > 0 && MONTH_FIRST_DAY[mon] > days) mon--;
    r.second = 6'(rem % 60);
    r.minute = 6'((rem / 60) % 60);
    r.hour   = 5'(rem / 3600);
    r.day    = 5'(days - MONTH_FIRST_DAY[mon] + 1);
    r.month  = 4'(mon + 1);
    r.year   = 12'(yr + YEAR_BASE);
    return r;
  endfunction

  function automatic in_item_t bcd_load(input logic [7:0] s, mi, h, d, mo, y);
    in_item_t it;
    it.func       = FUNC_LOAD;
    it.bcd_second = s;
    it.bcd_minute = mi;
    it.bcd_hour   = h;
    it.bcd_day    = d;
    it.bcd_month  = mo;
    it.bcd_year   = y;
    return it;
  endfunction

  function automatic out_item_t readout(input int unsigned s, mi, h, d, mo, y);
    out_item_t r;
    r.second = 6'(s);
    r.minute = 6'(mi);
    r.hour   = 5'(h);
    r.day    = 5'(d);
    r.month  = 4'(mo);
    r.year   = 12'(y);
    return r;
  endfunction

  function automatic void row_item(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.tps    = '0;
    row.stim   = it;
    row.typed  = typed;
    row.want   = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_cfg(input logic [15:0] v);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.tps    = v;
    row.stim   = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(input string fname, input logic [11:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Offers one transaction, waits for acceptance and queues its readout.
  task automatic send(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predicted = advance_calendar(it);
    expected_readout_q.push_back(typed ? want : predicted);
  endtask

  // Register writes only with the block drained.
  task automatic write_tps(input logic [15:0] v);
    push <= 1'b0;
    while (expected_readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_tps  = v;
  endtask

  // Result side: check popped transactions, then pick pop for the next cycle.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_readout_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatches++;
        end else begin
          want = expected_readout_q.pop_front();
          check_field("second", 12'(want.second), 12'(result.second));
          check_field("minute", 12'(want.minute), 12'(result.minute));
          check_field("hour", 12'(want.hour), 12'(result.hour));
          check_field("day", 12'(want.day), 12'(result.day));
          check_field("month", 12'(want.month), 12'(result.month));
          check_field("year", want.year, result.year);
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned tps_plan [NUM_PHASES];
    int unsigned roll, m, mlen;
    logic [63:0] noise;
    in_item_t    it;

    tps_plan = '{1, 100, 2, 7, 65535, 1, 0, 3, 1};

    // directed table
    row_item(TICK_ITEM, 1'b1, readout(0, 0, 0, 1, 1, 2000));
    // day zero and month zero both clamp to one
    row_item(bcd_load(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
             readout(0, 0, 0, 1, 1, 2000));
    row_item(bcd_load(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99), 1'b1,
             readout(59, 59, 23, 31, 12, 2099));
    row_item(TICK_ITEM, 1'b1, readout(59, 59, 23, 31, 12, 2099));
    row_item(bcd_load(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    row_item(bcd_load(8'h00, 8'h00, 8'h00, 8'h31, 8'h13, 8'h10), 1'b0, '0);
    row_item(bcd_load(8'h5A, 8'h0F, 8'h1A, 8'h0A, 8'h0A, 8'hA0), 1'b0, '0);
    row_item(bcd_load(8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99), 1'b0, '0);
    row_item(bcd_load(8'h01, 8'h02, 8'h03, 8'h15, 8'h00, 8'h01), 1'b0, '0);
    row_item(bcd_load(8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h24), 1'b0, '0);
    row_item(bcd_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h50), 1'b0, '0);
    row_item(bcd_load(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h07), 1'b0, '0);
    row_cfg(16'd1);
    row_item(bcd_load(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99), 1'b1,
             readout(59, 59, 23, 31, 12, 2099));
    // one second past 2099 wraps to the start of 2000
    row_item(TICK_ITEM, 1'b1, readout(0, 0, 0, 1, 1, 2000));
    row_item(bcd_load(8'h59, 8'h59, 8'h23, 8'h31, 8'h01, 8'h05), 1'b0, '0);
    row_item(TICK_ITEM, 1'b0, '0);
    row_item(bcd_load(8'h59, 8'h59, 8'h23, 8'h30, 8'h11, 8'h10), 1'b0, '0);
    row_item(TICK_ITEM, 1'b0, '0);
    row_item(bcd_load(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h41), 1'b0, '0);
    row_item(TICK_ITEM, 1'b0, '0);
    // zero means 65536 ticks per second
    row_cfg(16'd0);
    row_item(bcd_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00), 1'b1,
             readout(0, 0, 0, 1, 1, 2000));
    row_item(TICK_ITEM, 1'b1, readout(0, 0, 0, 1, 1, 2000));
    row_cfg(16'hFFFF);
    row_item(TICK_ITEM, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_tps(directed_rows[i].tps);
      else send(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases; a small limit after a large one catches a stale prescaler
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_tps(16'(tps_plan[ph]));
      if (ph == 1) hold_req <= 1'b1;
      if (ph == NUM_PHASES - 1) idle_on <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll  = $urandom_range(0, 99);
        noise = {$urandom, $urandom};
        it    = noise[$bits(in_item_t)-1:0];
        if (roll < 60) begin
          it.func = FUNC_TICK;
        end else if (roll < 85) begin
          // well-formed load, biased toward the edges of each unit
          m    = $urandom_range(1, 12);
          mlen = (m == 12) ? 365 - MONTH_FIRST_DAY[11]
                           : MONTH_FIRST_DAY[m] - MONTH_FIRST_DAY[m-1];
          it.func       = FUNC_LOAD;
          it.bcd_second = bin_to_bcd(($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59));
          it.bcd_minute = bin_to_bcd(($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59));
          it.bcd_hour   = bin_to_bcd(($urandom_range(0, 2) == 0) ? 23 : $urandom_range(0, 23));
          it.bcd_day    = bin_to_bcd(($urandom_range(0, 2) == 0) ? mlen
                                                                 : $urandom_range(1, mlen));
          it.bcd_month  = bin_to_bcd(m);
          it.bcd_year   = bin_to_bcd(($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99));
        end else begin
          it.func = FUNC_LOAD;
        end
        send(it, 1'b0, '0);
      end
    end

    push <= 1'b0;
    while (expected_readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tick_driven_calendar_clock regression: pass");
    else $display("tick_driven_calendar_clock regression: fail");
    $finish;
  end

endmodule
